// ===== src/salc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and codes for the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_INSTR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    OC_HIT   = 2'd0,
    OC_MISS  = 2'd1,
    OC_EVICT = 2'd2
  } outcome_e;

  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS       = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] address;
  } salc_in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        last;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;
  } salc_out_t;

  // Effective geometry, already clamped to what the storage supports.
  typedef struct packed {
    logic [3:0] set_bits;
    logic [4:0] block_bits;
    logic [3:0] ways;
  } salc_cfg_t;

endpackage

// ===== src/set_assoc_lru_cache_model.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative cache with exact LRU replacement and running counters.
// ----------------------------------------------------------------------------
// Each access passes through two steps in the back end: one reads the whole
// set row from the single-port row memory and one resolves the lookup and
// writes the row back, so a load or store passes once and a modify twice;
// an instruction fetch is taken and gives no result. Up to two accesses
// wait in the queue between the front and the back. After reset and after
// every write of the set bits, block bits or ways the row memory is cleared
// one set per cycle, all 2^floor(log2(MAX_SETS)) sets (1024 by default),
// during which no access is processed; the counters are kept across a write.
module set_assoc_lru_cache_model #(
  parameter int MAX_SETS   = 1024,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  salc_pkg::salc_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output salc_pkg::salc_out_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [4:0]           cfg_data_i
);

  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int SETS   = 1 << SB_MAX;
  localparam int SET_W  = (SB_MAX > 0) ? SB_MAX : 1;
  localparam int TAG_W  = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [3:0] set_bits_q;
  logic [4:0] block_bits_q;
  logic [3:0] ways_q;
  logic       cfg_we;
  logic       flush;
  salc_pkg::salc_cfg_t cfg;

  logic             q_valid, q_twice, q_pop;
  logic [SET_W-1:0] q_set;
  logic [TAG_W-1:0] q_tag;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign flush       = cfg_we && (cfg_index_i == salc_pkg::CFG_SET_BITS ||
                                  cfg_index_i == salc_pkg::CFG_BLOCK_BITS ||
                                  cfg_index_i == salc_pkg::CFG_WAYS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 4'd0;
      block_bits_q <= 5'd0;
      ways_q       <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index_i)
        salc_pkg::CFG_SET_BITS:   set_bits_q   <= cfg_data_i[3:0];
        salc_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_data_i;
        salc_pkg::CFG_WAYS:       ways_q       <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.set_bits   = (int'(set_bits_q) > SB_MAX) ? 4'(SB_MAX) : set_bits_q;
    cfg.block_bits = block_bits_q;
    if (ways_q == 4'd0) begin
      cfg.ways = 4'd1;
    end else if (int'(ways_q) > MAX_WAYS) begin
      cfg.ways = 4'(MAX_WAYS);
    end else begin
      cfg.ways = ways_q;
    end
  end

  salc_front #(
    .SET_W (SET_W),
    .TAG_W (TAG_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .q_valid_o  (q_valid),
    .q_set_o    (q_set),
    .q_tag_o    (q_tag),
    .q_twice_o  (q_twice),
    .q_pop_i    (q_pop)
  );

  salc_back #(
    .SET_W    (SET_W),
    .SETS     (SETS),
    .TAG_W    (TAG_W),
    .MAX_WAYS (MAX_WAYS),
    .RANK_W   (RANK_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .flush_i     (flush),
    .q_valid_i   (q_valid),
    .q_set_i     (q_set),
    .q_tag_i     (q_tag),
    .q_twice_i   (q_twice),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== src/salc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_front
// Accepts accesses, splits the address into set and tag, and queues them.
// ----------------------------------------------------------------------------
module salc_front #(
  parameter int SET_W = 10,
  parameter int TAG_W = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  salc_pkg::salc_in_t   in_data_i,
  input  salc_pkg::salc_cfg_t  cfg_i,
  output logic                 q_valid_o,
  output logic [SET_W-1:0]     q_set_o,
  output logic [TAG_W-1:0]     q_tag_o,
  output logic                 q_twice_o,
  input  logic                 q_pop_i
);

  logic [TAG_W-1:0] addr_m;
  logic [TAG_W-1:0] set_full;
  logic [SET_W-1:0] set_mask;
  logic [5:0]       shift;
  logic [SET_W-1:0] new_set;
  logic [TAG_W-1:0] new_tag;
  logic             push;

  logic [SET_W-1:0] ent_set_q   [2];
  logic [TAG_W-1:0] ent_tag_q   [2];
  logic             ent_twice_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign addr_m   = in_data_i.address[TAG_W-1:0];
  assign shift    = 6'(cfg_i.set_bits) + 6'(cfg_i.block_bits);
  assign new_tag  = addr_m >> shift;
  assign set_full = addr_m >> cfg_i.block_bits;
  assign set_mask = ~({SET_W{1'b1}} << cfg_i.set_bits);
  assign new_set  = set_full[SET_W-1:0] & set_mask;

  assign in_ready_o = (cnt_q != 2'd2);
  // Instruction fetches are taken and dropped here.
  assign push = in_valid_i && in_ready_o && (in_data_i.op != salc_pkg::OP_INSTR);

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_set_o   = ent_set_q[rd_ptr_q];
  assign q_tag_o   = ent_tag_q[rd_ptr_q];
  assign q_twice_o = ent_twice_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ q_pop_i;
    cnt_d    = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_set_q[wr_ptr_q]   <= new_set;
      ent_tag_q[wr_ptr_q]   <= new_tag;
      ent_twice_q[wr_ptr_q] <= (in_data_i.op == salc_pkg::OP_MODIFY);
    end
  end

endmodule

// ===== src/salc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_back
// Reads a set row, resolves hit, fill or eviction, writes the row back and
// presents the result with the running counters.
// ----------------------------------------------------------------------------
module salc_back #(
  parameter int SET_W    = 10,
  parameter int SETS     = 1024,
  parameter int TAG_W    = 32,
  parameter int MAX_WAYS = 8,
  parameter int RANK_W   = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  salc_pkg::salc_cfg_t  cfg_i,
  input  logic                 flush_i,
  input  logic                 q_valid_i,
  input  logic [SET_W-1:0]     q_set_i,
  input  logic [TAG_W-1:0]     q_tag_i,
  input  logic                 q_twice_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output salc_pkg::salc_out_t  out_data_o
);

  typedef struct packed {
    logic [MAX_WAYS-1:0]             valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
  } row_t;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_e;

  row_t mem_q [SETS];
  row_t rdata_q;
  row_t row_n;

  state_e            state_q, state_d;
  logic [SET_W-1:0]  clr_q, clr_d;
  logic              pend_q, pend_d;
  logic              second_q, second_d;
  logic              twice_q, twice_d;
  logic [SET_W-1:0]  set_q, set_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [31:0]       hits_q, hits_d, miss_q, miss_d, evict_q, evict_d;
  logic              out_valid_q, out_valid_d;
  salc_pkg::salc_out_t out_q, out_d;

  logic              rd_en;
  logic [SET_W-1:0]  rd_addr;
  logic              mem_we;
  logic [SET_W-1:0]  mem_waddr;
  row_t              mem_wdata;
  logic              commit;

  logic [MAX_WAYS-1:0] lane_on;
  logic                hit, free;
  logic [RANK_W-1:0]   hit_idx, free_idx, victim;
  logic [RANK_W-1:0]   hit_rank, wm1;
  logic [1:0]          outcome;

  // Tag compare and replacement choice over all lanes of the row.
  always_comb begin
    row_n    = rdata_q;
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    victim   = '0;
    wm1      = RANK_W'(cfg_i.ways - 4'd1);
    for (int i = 0; i < MAX_WAYS; i++) begin
      lane_on[i] = (i < int'(cfg_i.ways));
    end
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (lane_on[i] && rdata_q.valid[i] && rdata_q.tag[i] == tag_q) begin
        hit     = 1'b1;
        hit_idx = RANK_W'(i);
      end
      if (lane_on[i] && !rdata_q.valid[i]) begin
        free     = 1'b1;
        free_idx = RANK_W'(i);
      end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (lane_on[i] && rdata_q.rank[i] == wm1) begin
        victim = RANK_W'(i);
      end
    end
    hit_rank = rdata_q.rank[hit_idx];
    if (hit) begin
      outcome = salc_pkg::OC_HIT;
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (lane_on[j] && rdata_q.valid[j] && rdata_q.rank[j] < hit_rank) begin
          row_n.rank[j] = rdata_q.rank[j] + RANK_W'(1);
        end
      end
      row_n.rank[hit_idx] = '0;
    end else if (free) begin
      outcome = salc_pkg::OC_MISS;
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (lane_on[j] && rdata_q.valid[j]) begin
          row_n.rank[j] = rdata_q.rank[j] + RANK_W'(1);
        end
      end
      row_n.valid[free_idx] = 1'b1;
      row_n.tag[free_idx]   = tag_q;
      row_n.rank[free_idx]  = '0;
    end else begin
      outcome = salc_pkg::OC_EVICT;
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (lane_on[j] && rdata_q.rank[j] < wm1) begin
          row_n.rank[j] = rdata_q.rank[j] + RANK_W'(1);
        end
      end
      row_n.tag[victim]  = tag_q;
      row_n.rank[victim] = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pend_d      = pend_q;
    second_d    = second_q;
    twice_d     = twice_q;
    set_d       = set_q;
    tag_d       = tag_q;
    hits_d      = hits_q;
    miss_d      = miss_q;
    evict_d     = evict_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = set_q;
    mem_we      = 1'b0;
    mem_waddr   = set_q;
    mem_wdata   = row_n;
    q_pop_o     = 1'b0;
    commit      = 1'b0;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + SET_W'(1);
        if (clr_q == SET_W'(SETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pend_q) begin
          rd_en    = 1'b1;
          pend_d   = 1'b0;
          second_d = 1'b1;
          state_d  = S_LOOK;
        end else if (q_valid_i) begin
          rd_en    = 1'b1;
          rd_addr  = q_set_i;
          q_pop_o  = 1'b1;
          set_d    = q_set_i;
          tag_d    = q_tag_i;
          twice_d  = q_twice_i;
          second_d = 1'b0;
          state_d  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          mem_we  = 1'b1;
          state_d = S_IDLE;
          pend_d  = twice_q && !second_q;
        end
      end
      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
    if (commit) begin
      hits_d  = hits_q + 32'(outcome == salc_pkg::OC_HIT);
      miss_d  = miss_q + 32'(outcome != salc_pkg::OC_HIT);
      evict_d = evict_q + 32'(outcome == salc_pkg::OC_EVICT);
      out_valid_d          = 1'b1;
      out_d.outcome        = outcome;
      out_d.last           = !twice_q || second_q;
      out_d.hit_count      = hits_d;
      out_d.miss_count     = miss_d;
      out_d.eviction_count = evict_d;
    end
    // A geometry change empties the cache; counters are kept.
    if (flush_i) begin
      state_d = S_CLEAR;
      clr_d   = '0;
      pend_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      second_q    <= 1'b0;
      twice_q     <= 1'b0;
      hits_q      <= '0;
      miss_q      <= '0;
      evict_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      second_q    <= second_d;
      twice_q     <= twice_d;
      hits_q      <= hits_d;
      miss_q      <= miss_d;
      evict_q     <= evict_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q <= set_d;
    tag_q <= tag_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/salc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks for the cache model, bound to the top level.
// ----------------------------------------------------------------------------
module salc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input salc_pkg::salc_out_t  out_data_o
);

  // A stalled result must hold until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome == salc_pkg::OC_HIT |-> out_data_o.hit_count != 32'd0)
    else $error("hit reported with zero hit count");

  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome != salc_pkg::OC_HIT |-> out_data_o.miss_count != 32'd0)
    else $error("miss reported with zero miss count");

  a_evict_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome == salc_pkg::OC_EVICT
      |-> out_data_o.eviction_count != 32'd0)
    else $error("eviction reported with zero eviction count");

endmodule

bind set_assoc_lru_cache_model salc_checker u_salc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
